// ===== src/assert_macros.svh =====
// Assertion helpers used by the cluster merge datapath.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising edge of clk.
`define LSCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds.
`define LSCM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/lscm_pkg.sv =====
// ----------------------------------------------------------------------------
// lscm_pkg
// Types, sizes and constants of the line segment cluster merge block.
// ----------------------------------------------------------------------------
package lscm_pkg;

  localparam int MAX_CLUSTERS = 32;
  localparam int COORD_BITS   = 10;
  localparam int TOL_BITS     = 10;
  localparam int MEMB_BITS    = 8;
  localparam int IDX_BITS     = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_BITS     = $clog2(MAX_CLUSTERS + 1);

  localparam int IN_W   = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W  = ((4 * COORD_BITS + MEMB_BITS + 7) / 8) * 8;

  localparam logic [TOL_BITS-1:0]  TOL_RESET   = TOL_BITS'(50);
  localparam logic [MEMB_BITS-1:0] MEMBERS_MAX = MEMB_BITS'(255);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Box corners, start x in the lowest bits
  typedef struct packed {
    coord_t ey;
    coord_t ex;
    coord_t sy;
    coord_t sx;
  } box_t;

  typedef struct packed {
    logic [MEMB_BITS-1:0] members;
    box_t                 box;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_ISSUE,
    S_RD_LOAD
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic seg_load;
    logic ptr_clr;
    logic rd_en;
    logic wr_merge;
    logic wr_new;
    logic drop;
    logic out_load;
    logic tbl_clr;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic count_zero;
    logic full;
    logic rd_valid;
    logic match;
    logic cmp_last;
    logic issue_done;
    logic last_seg;
    logic out_free;
  } stat_t;

endpackage

// ===== src/lscm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lscm_ctrl
// Sequencer for the cluster merge: table scan per segment and frame readout.
// ----------------------------------------------------------------------------
module lscm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  lscm_pkg::stat_t st,
  output lscm_pkg::cmd_t  cmd
);
  import lscm_pkg::*;

  state_t state_r, state_nxt;
  logic   hit, miss;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign hit  = st.rd_valid && st.match;
  assign miss = st.count_zero || (st.rd_valid && !st.match && st.cmp_last);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.seg_load = 1'b1;
          cmd.ptr_clr  = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // keep reads streaming until a hit or the table end
        cmd.rd_en = !st.issue_done && !hit;
        if (hit || miss) begin
          cmd.wr_merge = hit;
          cmd.wr_new   = !hit && !st.full;
          cmd.drop     = !hit && st.full;
          cmd.ptr_clr  = 1'b1;
          state_nxt    = st.last_seg ? S_RD_ISSUE : S_IDLE;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_RD_LOAD;
      end
      S_RD_LOAD: begin
        // hold the read word until the output register frees up
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          if (st.cmp_last) begin
            cmd.tbl_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt   = S_RD_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lscm_dp.sv =====
// ----------------------------------------------------------------------------
// lscm_dp
// Cluster table memory, match and merge logic, tolerance register and the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lscm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lscm_pkg::cmd_t               cmd,
  output lscm_pkg::stat_t              st,
  input  logic [lscm_pkg::IN_W-1:0]    in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                         in_tlast,   // frame_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lscm_pkg::TOL_BITS-1:0] cfg_data,  // tolerance
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [lscm_pkg::OUT_W-1:0]   out_tdata,  // box_start_x, box_start_y,
                                                   // box_end_x, box_end_y, members
  output logic                         out_tuser,  // overflow
  output logic                         out_tlast   // last_cluster
);
  import lscm_pkg::*;

  localparam int CMP_W = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;

  entry_t               mem [MAX_CLUSTERS];
  box_t                 seg_r;
  logic                 last_r;
  logic [TOL_BITS-1:0]  tol_r;
  logic [CNT_BITS-1:0]  count_r;
  logic                 drop_r;
  logic [CNT_BITS-1:0]  rd_ptr_r;
  logic [CNT_BITS-1:0]  cmp_ptr_r;
  logic                 rd_valid_r;
  entry_t               rd_data_r;
  logic                 out_valid_r;
  entry_t               out_entry_r;
  logic                 out_ovf_r;
  logic                 out_last_r;
  entry_t               merged;
  entry_t               fresh;
  logic                 cmp_last;

  function automatic logic near(input coord_t a, input coord_t c,
                                input logic [TOL_BITS-1:0] tol);
    coord_t d;
    d = (a > c) ? (a - c) : (c - a);
    return CMP_W'(d) < CMP_W'(tol);
  endfunction

  // Tolerance register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // Latch the accepted segment
  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      seg_r  <= box_t'(in_tdata[4*COORD_BITS-1:0]);
      last_r <= in_tlast;
    end
  end

  // Merge of the segment into the word just read
  always_comb begin
    merged = rd_data_r;
    if (seg_r.sx < rd_data_r.box.sx) merged.box.sx = seg_r.sx;
    if (seg_r.sy < rd_data_r.box.sy) merged.box.sy = seg_r.sy;
    if (seg_r.ex > rd_data_r.box.ex) merged.box.ex = seg_r.ex;
    if (seg_r.ey > rd_data_r.box.ey) merged.box.ey = seg_r.ey;
    if (rd_data_r.members != MEMBERS_MAX) begin
      merged.members = rd_data_r.members + MEMB_BITS'(1);
    end
    fresh.box     = seg_r;
    fresh.members = MEMB_BITS'(1);
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_merge) begin
      mem[cmp_ptr_r[IDX_BITS-1:0]] <= merged;
    end else if (cmd.wr_new) begin
      mem[count_r[IDX_BITS-1:0]] <= fresh;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_ptr_r[IDX_BITS-1:0]];
      cmp_ptr_r <= rd_ptr_r;
    end
  end

  // Read pointer, fill count and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r   <= '0;
      rd_valid_r <= 1'b0;
      count_r    <= '0;
      drop_r     <= 1'b0;
    end else begin
      rd_valid_r <= cmd.rd_en;
      if (cmd.ptr_clr) begin
        rd_ptr_r <= '0;
      end else if (cmd.rd_en) begin
        rd_ptr_r <= rd_ptr_r + CNT_BITS'(1);
      end
      if (cmd.tbl_clr) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end else begin
        if (cmd.wr_new) count_r <= count_r + CNT_BITS'(1);
        if (cmd.drop)   drop_r  <= 1'b1;
      end
    end
  end

  assign cmp_last = (cmp_ptr_r == (count_r - CNT_BITS'(1)));

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_entry_r <= rd_data_r;
      out_ovf_r   <= drop_r;
      out_last_r  <= cmp_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_entry_r);
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  // Status to the controller
  always_comb begin
    st.count_zero = (count_r == '0);
    st.full       = (count_r == CNT_BITS'(MAX_CLUSTERS));
    st.rd_valid   = rd_valid_r;
    st.match      = near(seg_r.sx, rd_data_r.box.sx, tol_r) &&
                    near(seg_r.sy, rd_data_r.box.sy, tol_r) &&
                    near(seg_r.ex, rd_data_r.box.ex, tol_r) &&
                    near(seg_r.ey, rd_data_r.box.ey, tol_r);
    st.cmp_last   = cmp_last;
    st.issue_done = (rd_ptr_r == count_r);
    st.last_seg   = last_r;
    st.out_free   = !out_valid_r || out_tready;
  end

  `LSCM_ASSERT(a_count_bound, count_r <= CNT_BITS'(MAX_CLUSTERS), "cluster count above table size")
  `LSCM_NEVER(a_wr_excl, cmd.wr_merge && cmd.wr_new, "merge and append in one cycle")
  `LSCM_ASSERT(a_merge_rd, cmd.wr_merge |-> rd_valid_r, "merge without fresh read data")
  `LSCM_ASSERT(a_clr_empty, cmd.tbl_clr |=> (count_r == '0) && !drop_r, "table not cleared")
  `LSCM_NEVER(a_load_busy, cmd.out_load && out_valid_r && !out_tready, "output overwritten")

endmodule

// ===== src/line_segment_cluster_merge.sv =====
// ----------------------------------------------------------------------------
// line_segment_cluster_merge
// Leader clustering of the line segments of one frame into bounding boxes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one segment per beat; tdata holds start_x, start_y, end_x, end_y,
//            tlast marks the frame's last segment.
//   out_*  : one cluster per beat during readout; tdata holds the box corners
//            and the member count, tuser the overflow flag, tlast the final
//            cluster of the frame.
//   cfg_*  : write of the tolerance register, taken in any cycle; the user
//            writes it only while the block is idle, which the block does not enforce.
// Throughput: a segment occupies the block for the scan of N clusters, N being
//   the clusters scanned before the first hit (at most 32), set by the single
//   read port of the cluster table feeding one comparator per cycle.
// Readout on tlast follows the scan; each cluster passes S_RD_ISSUE, then
//   S_RD_LOAD. A stalled receiver holds the output register and the readout
//   waits on it. The next segment is taken once the last cluster is loaded.
// Reset: table empty, overflow clear, tolerance back to 50; no clearing pass.
// ----------------------------------------------------------------------------
module line_segment_cluster_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lscm_pkg::IN_W-1:0]     in_tdata,   // start_x, start_y, end_x, end_y
  input  logic                          in_tlast,   // frame_end
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lscm_pkg::OUT_W-1:0]    out_tdata,  // box_start_x, box_start_y,
                                                    // box_end_x, box_end_y, members
  output logic                          out_tuser,  // overflow
  output logic                          out_tlast,  // last_cluster
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lscm_pkg::TOL_BITS-1:0] cfg_data    // tolerance
);
  import lscm_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Sequencer
  lscm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Table and datapath
  lscm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== bench/tb_line_segment_cluster_merge.sv =====
// ----------------------------------------------------------------------------
// tb_line_segment_cluster_merge
// Self-checking bench for the line segment cluster merge block.
// Feeds frames of segments over the input stream, predicts the cluster table
// and its readout in a behavioral model, and compares every output beat field
// by field. Tolerance is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_line_segment_cluster_merge;
  timeunit 1ns;
  timeprecision 1ps;

  import lscm_pkg::*;

  localparam int SETTLE_CYCLES = 2 * MAX_CLUSTERS + 8;
  localparam int IDLE_PCT      = 21;

  typedef struct packed {
    box_t box;
    logic frame_end;
  } segment_t;

  typedef struct packed {
    box_t                 box;
    logic [MEMB_BITS-1:0] members;
    logic                 overflow;
    logic                 last_cl;
  } cluster_beat_t;

  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata   = '0;
  logic                in_tlast   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                out_tuser;
  logic                out_tlast;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [TOL_BITS-1:0] cfg_data   = '0;

  // Pending segments, expected readout and the bench's copy of the block state
  segment_t            seg_queue[$];
  cluster_beat_t       expected_boxes[$];
  segment_t            cur_seg;
  box_t                box_tbl[MAX_CLUSTERS];
  logic [MEMB_BITS-1:0] member_tbl[MAX_CLUSTERS];
  int                  open_count   = 0;
  bit                  drop_seen    = 1'b0;
  logic [TOL_BITS-1:0] tol_reg      = TOL_RESET;
  bit                  steady       = 1'b0;
  int                  mismatch_count = 0;

  line_segment_cluster_merge uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit close_enough(coord_t a, coord_t b);
    int d;
    d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    return d < int'(tol_reg);
  endfunction

  // Merge one segment into the table; on frame end queue the readout and clear
  task automatic merge_segment(input segment_t s);
    bit            joined;
    cluster_beat_t beat;
    joined = 1'b0;
    for (int i = 0; i < open_count && !joined; i++) begin
      if (close_enough(s.box.sx, box_tbl[i].sx) && close_enough(s.box.sy, box_tbl[i].sy) &&
          close_enough(s.box.ex, box_tbl[i].ex) && close_enough(s.box.ey, box_tbl[i].ey)) begin
        if (s.box.sx < box_tbl[i].sx) box_tbl[i].sx = s.box.sx;
        if (s.box.sy < box_tbl[i].sy) box_tbl[i].sy = s.box.sy;
        if (s.box.ex > box_tbl[i].ex) box_tbl[i].ex = s.box.ex;
        if (s.box.ey > box_tbl[i].ey) box_tbl[i].ey = s.box.ey;
        if (member_tbl[i] != MEMBERS_MAX) member_tbl[i] = member_tbl[i] + 1'b1;
        joined = 1'b1;
      end
    end
    if (!joined) begin
      if (open_count < MAX_CLUSTERS) begin
        box_tbl[open_count]    = s.box;
        member_tbl[open_count] = MEMB_BITS'(1);
        open_count++;
      end else begin
        drop_seen = 1'b1;
      end
    end
    if (s.frame_end) begin
      for (int i = 0; i < open_count; i++) begin
        beat.box      = box_tbl[i];
        beat.members  = member_tbl[i];
        beat.overflow = drop_seen;
        beat.last_cl  = (i == open_count - 1);
        expected_boxes = {expected_boxes, beat};
      end
      open_count = 0;
      drop_seen  = 1'b0;
    end
  endtask

  // Present segments, hold each beat until taken, insert random gaps
  always @(posedge clk) begin : segment_driver
    segment_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) merge_segment(cur_seg);
      if (!in_tvalid || in_tready) begin
        if (seg_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = seg_queue.pop_front();
          cur_seg   <= nxt;
          in_tdata  <= IN_W'({nxt.box.ey, nxt.box.ex, nxt.box.sy, nxt.box.sx});
          in_tlast  <= nxt.frame_end;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each result beat against the oldest expected cluster
  always @(posedge clk) begin : result_monitor
    entry_t        got;
    cluster_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = entry_t'(out_tdata[4*COORD_BITS+MEMB_BITS-1:0]);
        if (expected_boxes.size() == 0) begin
          $error("result beat with no cluster pending: box %0d,%0d-%0d,%0d",
                 got.box.sx, got.box.sy, got.box.ex, got.box.ey);
          mismatch_count++;
        end else begin
          want = expected_boxes.pop_front();
          if (got.box.sx !== want.box.sx) begin
            $error("box_start_x: expected %0d, actual %0d", want.box.sx, got.box.sx);
            mismatch_count++;
          end
          if (got.box.sy !== want.box.sy) begin
            $error("box_start_y: expected %0d, actual %0d", want.box.sy, got.box.sy);
            mismatch_count++;
          end
          if (got.box.ex !== want.box.ex) begin
            $error("box_end_x: expected %0d, actual %0d", want.box.ex, got.box.ex);
            mismatch_count++;
          end
          if (got.box.ey !== want.box.ey) begin
            $error("box_end_y: expected %0d, actual %0d", want.box.ey, got.box.ey);
            mismatch_count++;
          end
          if (got.members !== want.members) begin
            $error("members: expected %0d, actual %0d", want.members, got.members);
            mismatch_count++;
          end
          if (out_tuser !== want.overflow) begin
            $error("overflow: expected %0d, actual %0d", want.overflow, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.last_cl) begin
            $error("last_cluster: expected %0d, actual %0d", want.last_cl, out_tlast);
            mismatch_count++;
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic push_seg(input int sx, input int sy, input int ex, input int ey,
                          input bit fe);
    segment_t s;
    s.box.sx    = coord_t'(sx);
    s.box.sy    = coord_t'(sy);
    s.box.ex    = coord_t'(ex);
    s.box.ey    = coord_t'(ey);
    s.frame_end = fe;
    seg_queue = {seg_queue, s};
  endtask

  // Hold the sender until every segment is taken and every cluster has come back;
  // sample away from the rising edge so the driver's updates are settled
  task automatic drain_phase();
    do @(negedge clk);
    while (seg_queue.size() != 0 || in_tvalid || expected_boxes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_BITS-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_reg = v;
  endtask

  function automatic int nudge(coord_t c, int j);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * j)) - j;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v;
  endfunction

  // Frames of segments gathered around a few seed boxes, with some noise
  task automatic random_frame(input int n_seg);
    box_t seeds[3];
    int   j;
    int   k;
    j = (int'(tol_reg) > 100) ? 100 : int'(tol_reg) + 2;
    foreach (seeds[i]) seeds[i] = box_t'((4*COORD_BITS)'({$urandom, $urandom}));
    for (int n = 0; n < n_seg; n++) begin
      if ($urandom_range(3) != 0) begin
        k = $urandom_range(2);
        push_seg(nudge(seeds[k].sx, j), nudge(seeds[k].sy, j),
                 nudge(seeds[k].ex, j), nudge(seeds[k].ey, j), n == n_seg - 1);
      end else begin
        push_seg($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1023), n == n_seg - 1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset tolerance: join just inside the window, miss at its edge, corners
    push_seg(100, 100, 200, 200, 0);
    push_seg(149, 51, 151, 249, 0);
    push_seg(150, 100, 200, 200, 0);
    push_seg(0, 0, 0, 0, 0);
    push_seg(1023, 1023, 1023, 1023, 1);
    drain_phase();

    // Zero tolerance: identical segments still open separate clusters
    write_tolerance(10'd0);
    push_seg(7, 7, 7, 7, 0);
    push_seg(7, 7, 7, 7, 0);
    push_seg(7, 7, 7, 7, 1);
    push_seg(512, 512, 512, 512, 1);
    drain_phase();

    // Widest tolerance: only a full-scale difference misses
    write_tolerance(10'd1023);
    push_seg(0, 0, 0, 0, 0);
    push_seg(1023, 1023, 1023, 1023, 0);
    push_seg(1022, 1, 1022, 1, 0);
    push_seg(1, 1022, 1, 1022, 1);
    drain_phase();

    // Unit tolerance: exact match joins, one pixel off does not
    write_tolerance(10'd1);
    push_seg(300, 300, 300, 300, 0);
    push_seg(300, 300, 300, 300, 0);
    push_seg(301, 300, 300, 300, 1);
    drain_phase();

    // Table full: drop two segments, then a frame that shows the flag cleared
    write_tolerance(10'd0);
    for (int n = 0; n < 34; n++)
      push_seg($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
               $urandom_range(1023), n == 33);
    push_seg($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
             $urandom_range(1023), 0);
    push_seg($urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
             $urandom_range(1023), 1);
    drain_phase();

    // Member count saturation, with both sides streaming without gaps
    write_tolerance(10'd1023);
    steady = 1'b1;
    for (int n = 0; n < 260; n++)
      push_seg($urandom_range(1, 1022), $urandom_range(1, 1022), $urandom_range(1, 1022),
               $urandom_range(1, 1022), n == 259);
    drain_phase();
    steady = 1'b0;

    // Random tolerance per phase, random frames within it
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(3))
        0: write_tolerance(TOL_BITS'($urandom_range(1023)));
        1: write_tolerance(TOL_BITS'($urandom_range(1, 80)));
        2: write_tolerance($urandom_range(1) ? 10'd1023 : 10'd0);
        default: write_tolerance(TOL_BITS'($urandom_range(20, 200)));
      endcase
      repeat ($urandom_range(2, 4)) random_frame($urandom_range(1, 8));
      drain_phase();
    end

    if (mismatch_count == 0 && expected_boxes.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Bound the run
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
